// ----- rtl/todc_pkg.sv -----
// Shared types and constants for the time-of-day clock with staged set.
package todc_pkg;

    localparam int DEF_TICKS_PER_SECOND = 100;
    localparam int DEF_LED_STEP_TICKS   = 50;

    localparam int S_TDATA_W = 40;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 32;

    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;
    localparam int SECONDS_PER_MIN  = 60;
    localparam int MIN_TEXT_LENGTH  = 5;

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_NINE = 8'h39;

    typedef enum logic [1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_SYNC = 2'd2,
        CMD_POLL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SYNTAX    = 2'd1,
        ST_VALUE     = 2'd2,
        ST_RESERVED  = 2'd3
    } status_t;

    function automatic logic is_digit(input logic [7:0] ch);
        return (ch >= ASCII_ZERO) && (ch <= ASCII_NINE);
    endfunction

    // Two ASCII digits to a binary value 0..99.
    function automatic logic [6:0] two_digits(input logic [7:0] tens, input logic [7:0] ones);
        logic [6:0] t;
        logic [6:0] o;
        t = {3'b000, tens[3:0]};
        o = {3'b000, ones[3:0]};
        return (t << 3) + (t << 1) + o;
    endfunction

endpackage

// ----- rtl/time_of_day_clock_with_staged_set.sv -----
// Time-of-day clock with staged set: top level.
//
// A 24-hour clock advanced by tick requests (one tick is one centisecond at the default
// TICKS_PER_SECOND). Every request - tick, set time, synchronize or poll - yields exactly
// one result carrying the current time, LED pattern, set status and change flag. The block
// accepts one request per clock cycle; the only limit is the single output register, which
// holds a result while m_tready is low and frees up in the same cycle it is taken. The
// result is registered and appears in the cycle after its request is accepted. Set time
// stages HH:MM after checking length (syntax error below 5) and digits/range (value error);
// synchronize loads the staged time and clears seconds and centiseconds.
module time_of_day_clock_with_staged_set #(
    parameter int TICKS_PER_SECOND = todc_pkg::DEF_TICKS_PER_SECOND,
    parameter int LED_STEP_TICKS   = todc_pkg::DEF_LED_STEP_TICKS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [7:0] hour_tens_char, [15:8] hour_ones_char, [23:16] minute_tens_char,
    // [31:24] minute_ones_char, [35:32] text_length, [36] flag_next_value, [39:37] zero
    input  logic [todc_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] command
    input  logic [todc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [4:0] hours, [10:5] minutes, [16:11] seconds, [23:17] centiseconds,
    // [27:24] led_mask, [29:28] status, [30] changed_flag, [31] zero
    output logic [todc_pkg::M_TDATA_W-1:0] m_tdata
);
    import todc_pkg::*;

    localparam int CW = (TICKS_PER_SECOND > 2) ? $clog2(TICKS_PER_SECOND) : 1;
    localparam int LW = (LED_STEP_TICKS > 1) ? $clog2(LED_STEP_TICKS) : 1;
    localparam logic [CW-1:0] CENTI_LAST = CW'(TICKS_PER_SECOND - 1);
    localparam logic [LW-1:0] LED_LAST   = LW'(LED_STEP_TICKS - 1);

    // State
    logic [CW-1:0] centi_reg, centi_next;
    logic [LW-1:0] led_cnt_reg, led_cnt_next;
    logic [5:0]    sec_reg, sec_next;
    logic [5:0]    min_reg, min_next;
    logic [4:0]    hour_reg, hour_next;
    logic [4:0]    staged_hours_reg, staged_hours_next;
    logic [5:0]    staged_min_reg, staged_min_next;
    logic [3:0]    led_reg, led_next;
    logic          changed_reg, changed_next;
    logic          m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    // Request fields
    cmd_t       cmd;
    logic [7:0] hour_tens, hour_ones, min_tens, min_ones;
    logic [3:0] text_length;
    logic       flag_next_value;

    logic       accept;
    status_t    status;
    logic       flag_out;
    logic [6:0] set_hours, set_minutes;
    logic [3:0] led_shift;

    assign cmd             = cmd_t'(s_tuser[1:0]);
    assign hour_tens       = s_tdata[7:0];
    assign hour_ones       = s_tdata[15:8];
    assign min_tens        = s_tdata[23:16];
    assign min_ones        = s_tdata[31:24];
    assign text_length     = s_tdata[35:32];
    assign flag_next_value = s_tdata[36];

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    assign set_hours   = two_digits(hour_tens, hour_ones);
    assign set_minutes = two_digits(min_tens, min_ones);
    assign led_shift   = {led_reg[2:0], 1'b0};

    always_comb begin
        centi_next        = centi_reg;
        led_cnt_next      = led_cnt_reg;
        sec_next          = sec_reg;
        min_next          = min_reg;
        hour_next         = hour_reg;
        staged_hours_next = staged_hours_reg;
        staged_min_next   = staged_min_reg;
        led_next          = led_reg;
        changed_next      = changed_reg;
        status            = ST_OK;

        unique case (cmd)
            CMD_TICK: begin
                // LED phase counter tracks centi count modulo the LED step
                if (led_cnt_reg == LED_LAST) begin
                    led_cnt_next = '0;
                    led_next     = (led_shift == 4'd0) ? 4'd1 : led_shift;
                end else begin
                    led_cnt_next = led_cnt_reg + 1'b1;
                end
                if (centi_reg == CENTI_LAST) begin
                    centi_next   = '0;
                    led_cnt_next = '0;
                    changed_next = 1'b1;
                    if (sec_reg == 6'(SECONDS_PER_MIN - 1)) begin
                        sec_next = '0;
                        if (min_reg == 6'(MINUTES_PER_HOUR - 1)) begin
                            min_next  = '0;
                            hour_next = (hour_reg == 5'(HOURS_PER_DAY - 1)) ?
                                        5'd0 : hour_reg + 1'b1;
                        end else begin
                            min_next = min_reg + 1'b1;
                        end
                    end else begin
                        sec_next = sec_reg + 1'b1;
                    end
                end else begin
                    centi_next = centi_reg + 1'b1;
                end
            end
            CMD_SET: begin
                priority if (text_length < 4'(MIN_TEXT_LENGTH)) begin
                    status = ST_SYNTAX;
                end else if (!is_digit(hour_tens) || !is_digit(hour_ones) ||
                             !is_digit(min_tens) || !is_digit(min_ones)) begin
                    status = ST_VALUE;
                end else if (set_hours > 7'(HOURS_PER_DAY - 1) ||
                             set_minutes > 7'(MINUTES_PER_HOUR - 1)) begin
                    status = ST_VALUE;
                end else begin
                    staged_hours_next = set_hours[4:0];
                    staged_min_next   = set_minutes[5:0];
                end
            end
            CMD_SYNC: begin
                hour_next    = staged_hours_reg;
                min_next     = staged_min_reg;
                sec_next     = '0;
                centi_next   = '0;
                led_cnt_next = '0;
            end
            CMD_POLL: begin
                changed_next = flag_next_value;
            end
            default: ;
        endcase

        flag_out = (cmd == CMD_POLL) ? changed_reg : changed_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centi_reg        <= '0;
            led_cnt_reg      <= '0;
            sec_reg          <= '0;
            min_reg          <= '0;
            hour_reg         <= '0;
            staged_hours_reg <= '0;
            staged_min_reg   <= '0;
            led_reg          <= 4'd1;
            changed_reg      <= 1'b1;
            m_tvalid_reg     <= 1'b0;
        end else begin
            if (accept) begin
                centi_reg        <= centi_next;
                led_cnt_reg      <= led_cnt_next;
                sec_reg          <= sec_next;
                min_reg          <= min_next;
                hour_reg         <= hour_next;
                staged_hours_reg <= staged_hours_next;
                staged_min_reg   <= staged_min_next;
                led_reg          <= led_next;
                changed_reg      <= changed_next;
                m_tvalid_reg     <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= {1'b0, flag_out, status, led_next, 7'(centi_next),
                            sec_next, min_next, hour_next};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Checks
    a_led_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot(led_reg))
        else $error("LED pattern lost one-hot form");

    a_time_range: assert property (@(posedge aclk) disable iff (!aresetn)
        hour_reg <= 5'(HOURS_PER_DAY - 1) && min_reg <= 6'(MINUTES_PER_HOUR - 1) &&
        sec_reg <= 6'(SECONDS_PER_MIN - 1) && centi_reg <= CENTI_LAST)
        else $error("time field out of range");

    a_sync_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && cmd == CMD_SYNC |=> centi_reg == '0 && sec_reg == '0 && led_cnt_reg == '0)
        else $error("synchronize did not clear seconds");

    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid_reg && m_tdata_reg[23:17] == 7'(centi_reg))
        else $error("result does not match updated state");

endmodule

// ----- tb/sv/time_of_day_clock_with_staged_set_test.sv -----
// Self-checking stream testbench for the time-of-day clock with staged set.
`timescale 1ns / 1ps

module time_of_day_clock_with_staged_set_test;
    import todc_pkg::*;

    localparam int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND;
    localparam int LED_STEP_TICKS   = DEF_LED_STEP_TICKS;
    localparam int HOLD_CYCLES      = 150;
    localparam int RANDOM_ITEMS     = 1060;
    localparam int CARRY_TICKS      = TICKS_PER_SECOND * 2 + 20;
    localparam int DRAIN_LIMIT      = 20000;

    // Request payload as carried on s_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [2:0] pad;
        logic       next_flag;
        logic [3:0] text_len;
        logic [7:0] min_ones;
        logic [7:0] min_tens;
        logic [7:0] hour_ones;
        logic [7:0] hour_tens;
    } clock_request_t;

    // Result as carried on m_tdata.
    typedef struct packed {
        logic       pad;
        logic       changed;
        status_t    status;
        logic [3:0] led;
        logic [6:0] centis;
        logic [5:0] secs;
        logic [5:0] mins;
        logic [4:0] hours;
    } clock_reading_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    time_of_day_clock_with_staged_set #(
        .TICKS_PER_SECOND(TICKS_PER_SECOND),
        .LED_STEP_TICKS  (LED_STEP_TICKS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always #6 aclk = ~aclk;

    // Predicted clock state.
    int   tod_centi   = 0;
    int   tod_sec     = 0;
    int   tod_min     = 0;
    int   tod_hour    = 0;
    int   stage_hour  = 0;
    int   stage_min   = 0;
    logic [3:0] led_ring = 4'd1;
    logic sec_rolled  = 1'b1;

    clock_reading_t expected_readings[$];
    clock_reading_t seen_reading;
    clock_reading_t due_reading;

    int errors       = 0;
    int n_requests   = 0;
    int n_ticks      = 0;
    int n_sets       = 0;
    int n_syntax     = 0;
    int n_value      = 0;
    int n_syncs      = 0;
    int n_polls      = 0;
    int n_day_wraps  = 0;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_request   = 1'b0;
    int hold_left      = 0;

    function automatic clock_reading_t advance_clock(input cmd_t cmd,
                                                     input clock_request_t req);
        clock_reading_t rd;
        status_t        st;
        logic [7:0]     ch [4];
        logic           flag_before;
        bit             bad_char;
        int             h;
        int             m;
        st          = ST_OK;
        flag_before = sec_rolled;
        n_requests++;
        case (cmd)
            CMD_TICK: begin
                n_ticks++;
                tod_centi++;
                if (tod_centi % LED_STEP_TICKS == 0)
                    led_ring = led_ring << 1;
                if (led_ring == 4'd0)
                    led_ring = 4'd1;
                if (tod_centi >= TICKS_PER_SECOND) begin
                    tod_centi  = 0;
                    tod_sec++;
                    sec_rolled = 1'b1;
                end
                if (tod_sec >= SECONDS_PER_MIN) begin
                    tod_sec = 0;
                    tod_min++;
                end
                if (tod_min >= MINUTES_PER_HOUR) begin
                    tod_min = 0;
                    tod_hour++;
                end
                if (tod_hour >= HOURS_PER_DAY) begin
                    tod_hour = 0;
                    n_day_wraps++;
                end
            end
            CMD_SET: begin
                n_sets++;
                ch[0] = req.hour_tens;
                ch[1] = req.hour_ones;
                ch[2] = req.min_tens;
                ch[3] = req.min_ones;
                bad_char = 1'b0;
                for (int i = 0; i < 4; i++)
                    if (ch[i] < ASCII_ZERO || ch[i] > ASCII_NINE)
                        bad_char = 1'b1;
                if (req.text_len < MIN_TEXT_LENGTH) begin
                    st = ST_SYNTAX;
                end else if (bad_char) begin
                    st = ST_VALUE;
                end else begin
                    h = int'(ch[0] - ASCII_ZERO) * 10 + int'(ch[1] - ASCII_ZERO);
                    m = int'(ch[2] - ASCII_ZERO) * 10 + int'(ch[3] - ASCII_ZERO);
                    if (h >= HOURS_PER_DAY || m >= MINUTES_PER_HOUR) begin
                        st = ST_VALUE;
                    end else begin
                        stage_hour = h;
                        stage_min  = m;
                    end
                end
                if (st == ST_SYNTAX)
                    n_syntax++;
                if (st == ST_VALUE)
                    n_value++;
            end
            CMD_SYNC: begin
                n_syncs++;
                tod_hour  = stage_hour;
                tod_min   = stage_min;
                tod_sec   = 0;
                tod_centi = 0;
            end
            default: begin
                n_polls++;
                sec_rolled = req.next_flag;
            end
        endcase
        rd         = '0;
        rd.hours   = 5'(tod_hour);
        rd.mins    = 6'(tod_min);
        rd.secs    = 6'(tod_sec);
        rd.centis  = 7'(tod_centi);
        rd.led     = led_ring;
        rd.status  = st;
        rd.changed = (cmd == CMD_POLL) ? flag_before : sec_rolled;
        return rd;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // Predict on each accepted request, then compare each accepted result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                expected_readings.push_back(advance_clock(cmd_t'(s_tuser),
                                                          clock_request_t'(s_tdata)));
            if (m_tvalid && m_tready) begin
                seen_reading = clock_reading_t'(m_tdata);
                if (expected_readings.size() == 0) begin
                    $display("%0t ns: result %h with no request pending", $time, m_tdata);
                    errors++;
                end else begin
                    due_reading = expected_readings.pop_front();
                    check_field("hours", due_reading.hours, seen_reading.hours);
                    check_field("minutes", due_reading.mins, seen_reading.mins);
                    check_field("seconds", due_reading.secs, seen_reading.secs);
                    check_field("centiseconds", due_reading.centis, seen_reading.centis);
                    check_field("led_mask", due_reading.led, seen_reading.led);
                    check_field("status", due_reading.status, seen_reading.status);
                    check_field("changed_flag", due_reading.changed, seen_reading.changed);
                end
            end
        end
    end

    // Receiver: random stalls, or a long counted hold-off when asked.
    always @(negedge aclk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Enter and leave at a falling edge.
    task automatic send_request(input cmd_t cmd, input clock_request_t req);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= req;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    function automatic clock_request_t random_payload();
        clock_request_t req;
        req           = '0;
        req.hour_tens = 8'($urandom);
        req.hour_ones = 8'($urandom);
        req.min_tens  = 8'($urandom);
        req.min_ones  = 8'($urandom);
        req.text_len  = 4'($urandom);
        req.next_flag = 1'($urandom);
        return req;
    endfunction

    function automatic clock_request_t time_text(input int hh, input int mm,
                                                 input logic [3:0] len);
        clock_request_t req;
        req           = '0;
        req.hour_tens = ASCII_ZERO + 8'(hh / 10);
        req.hour_ones = ASCII_ZERO + 8'(hh % 10);
        req.min_tens  = ASCII_ZERO + 8'(mm / 10);
        req.min_ones  = ASCII_ZERO + 8'(mm % 10);
        req.text_len  = len;
        return req;
    endfunction

    function automatic clock_request_t poll_with(input logic next_value);
        clock_request_t req;
        req           = random_payload();
        req.next_flag = next_value;
        return req;
    endfunction

    task automatic test_directed_commands();
        clock_request_t req;
        send_request(CMD_TICK, '0);
        send_request(CMD_POLL, poll_with(1'b0));
        send_request(CMD_POLL, poll_with(1'b1));
        send_request(CMD_POLL, poll_with(1'b0));
        send_request(CMD_SET, time_text(12, 34, 4'd4));
        send_request(CMD_SET, time_text(12, 34, 4'd0));
        send_request(CMD_SET, time_text(23, 59, 4'd15));
        // Non-digit characters just outside and far from the digit range.
        req = time_text(10, 10, 4'd5);
        req.hour_tens = ASCII_ZERO - 8'd1;
        send_request(CMD_SET, req);
        req = time_text(10, 10, 4'd5);
        req.min_ones = ASCII_NINE + 8'd1;
        send_request(CMD_SET, req);
        req = time_text(10, 10, 4'd5);
        req.hour_ones = 8'hFF;
        send_request(CMD_SET, req);
        req = time_text(10, 10, 4'd5);
        req.min_tens = 8'h00;
        send_request(CMD_SET, req);
        send_request(CMD_SET, time_text(24, 0, 4'd5));
        send_request(CMD_SET, time_text(0, 60, 4'd5));
        send_request(CMD_SYNC, random_payload());
        repeat (3) send_request(CMD_TICK, random_payload());
        send_request(CMD_SET, time_text(0, 0, 4'd5));
        send_request(CMD_SYNC, '0);
        send_request(CMD_SET, time_text(19, 7, 4'd5));
        send_request(CMD_POLL, poll_with(1'b1));
        send_request(CMD_SYNC, '0);
    endtask

    // Run from 23:59:00 across a few second boundaries and LED steps.
    task automatic test_second_carry();
        send_request(CMD_SET, time_text(23, 59, 4'd5));
        send_request(CMD_SYNC, '0);
        repeat (CARRY_TICKS)
            send_request(CMD_TICK, random_payload());
    endtask

    // Hold the output off while requests keep coming, so the block stalls its input.
    task automatic test_backpressure_fill();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        hold_request = 1'b1;
        @(negedge aclk);
        repeat (40)
            send_request($urandom_range(3) == 0 ? CMD_POLL : CMD_TICK, random_payload());
    endtask

    task automatic random_set_text(output clock_request_t req);
        int pick;
        pick = $urandom_range(99);
        if (pick < 55) begin
            req = time_text($urandom_range(23), $urandom_range(59), 4'($urandom_range(5, 15)));
        end else if (pick < 65) begin
            req = random_payload();
            req.text_len = 4'($urandom_range(4));
        end else if (pick < 75) begin
            if ($urandom_range(1))
                req = time_text($urandom_range(24, 99), $urandom_range(59), 4'd5);
            else
                req = time_text($urandom_range(23), $urandom_range(60, 99), 4'd5);
        end else if (pick < 85) begin
            req = time_text($urandom_range(23), $urandom_range(59), 4'($urandom_range(5, 15)));
            case ($urandom_range(3))
                0: req.hour_tens = 8'($urandom);
                1: req.hour_ones = 8'($urandom);
                2: req.min_tens  = 8'($urandom);
                default: req.min_ones = 8'($urandom);
            endcase
        end else begin
            req = random_payload();
        end
        req.next_flag = 1'($urandom);
    endtask

    task automatic test_random_mix();
        clock_request_t req;
        int             pick;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            repeat (RANDOM_ITEMS / 4) begin
                pick = $urandom_range(99);
                if (pick < 80) begin
                    send_request(CMD_TICK, random_payload());
                end else if (pick < 88) begin
                    random_set_text(req);
                    send_request(CMD_SET, req);
                end else if (pick < 93) begin
                    send_request(CMD_SYNC, random_payload());
                end else begin
                    send_request(CMD_POLL, random_payload());
                end
            end
        end
    endtask

    task automatic wait_drained(output bit ok);
        int waited;
        waited         = 0;
        recv_stall_pct = 0;
        while (expected_readings.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        ok = (expected_readings.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        bit drained;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed_commands();
        test_second_carry();
        test_backpressure_fill();
        test_random_mix();
        s_tvalid <= 1'b0;
        wait_drained(drained);
        if (!drained) begin
            $display("%0t ns: %0d results never arrived", $time, expected_readings.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            $display("Ran %0d requests: %0d ticks, %0d set time (%0d syntax, %0d value errors),",
                     n_requests, n_ticks, n_sets, n_syntax, n_value);
            $display("%0d sync, %0d polls, %0d day wraps, one %0d-cycle output hold-off.",
                     n_syncs, n_polls, n_day_wraps, HOLD_CYCLES);
            if (errors == 0)
                $display("SCOREBOARD CLEAN");
            else
                $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        #5_000_000;
        $display("%0t ns: run did not finish in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- files.f -----
rtl/todc_pkg.sv
rtl/time_of_day_clock_with_staged_set.sv
tb/sv/time_of_day_clock_with_staged_set_test.sv
